FILE: sv/rsma_pkg.sv
`default_nettype none

package rsma_pkg;

  localparam int WIN_BITS = 7;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_SAMPLE_BITS = 10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: sv/running_sum_moving_average_unit.sv
// Running-sum moving average over converter samples.
// Input channel: in_valid/in_ready with sample_value, one sample per item.
// Output channel: out_valid/out_ready with filtered_value (window average,
// truncated) and previous_value (filtered_value of the item before).
// Configuration: window_size is written at any edge with cfg_we high; values
// above MAX_WINDOW saturate, 0 passes samples straight through. A write clears
// the sample store, the running total and the write index.
// With averaging on, an accepted item passes through the states READ, DIV and
// HOLD: READ reads the old entry from the store, DIV produces one quotient bit
// per cycle in the restoring divider, and HOLD loads the output register.
// Bypassed items go straight to HOLD. Items are handled one at a time, and the
// next is accepted once HOLD has loaded the output register.
// The store is cleared logically by a fill count: entries not yet written since
// reset or the last window write read as zero, so no clearing pass is needed.
// Reset (rst, synchronous) empties the pipeline and clears window_size, the
// total, the index and the previous value. If the receiver stalls, the result
// waits in the output register; the next item may be accepted and worked on,
// and waits before the output register until it is free.
`default_nettype none

module running_sum_moving_average_unit #(
  parameter int MAX_WINDOW  = rsma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = rsma_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rsma_pkg::WIN_BITS-1:0] window_size,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [SAMPLE_BITS-1:0]       sample_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]            filtered_value,
  output logic [SAMPLE_BITS-1:0]            previous_value
);
  import rsma_pkg::*;

  localparam int IDX_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_BITS   = $clog2(TOTAL_BITS);
  localparam int CMP_BITS   = (IDX_BITS + 1 > WIN_BITS) ? IDX_BITS + 1 : WIN_BITS;

  state_t                 state;
  logic [WIN_BITS-1:0]    window;
  logic [TOTAL_BITS-1:0]  total;
  logic [IDX_BITS-1:0]    idx;
  logic [FILL_BITS-1:0]   fill;
  logic [SAMPLE_BITS-1:0] last_output;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   mem_we;

  logic [SAMPLE_BITS-1:0] sample;
  logic [TOTAL_BITS-1:0]  quo;
  logic [WIN_BITS-1:0]    rem;
  logic [CNT_BITS-1:0]    cnt;

  logic [SAMPLE_BITS-1:0] old_value;
  logic [TOTAL_BITS-1:0]  total_next;
  logic [IDX_BITS-1:0]    idx_next;
  logic [WIN_BITS:0]      rem_sh;
  logic [WIN_BITS:0]      rem_dif;
  logic                   rem_ge;
  logic                   in_acc;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mem_we   = (state == ST_READ);

  always_comb begin
    old_value  = (FILL_BITS'(idx) < fill) ? rd_data : '0;
    total_next = total + TOTAL_BITS'(sample) - TOTAL_BITS'(old_value);
    if (CMP_BITS'(idx) + CMP_BITS'(1) >= CMP_BITS'(window)) begin
      idx_next = '0;
    end else begin
      idx_next = idx + IDX_BITS'(1);
    end
    rem_sh  = {rem, quo[TOTAL_BITS-1]};
    rem_ge  = (rem_sh >= {1'b0, window});
    rem_dif = rem_sh - {1'b0, window};
  end

  // sample store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= sample;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      window      <= '0;
      total       <= '0;
      idx         <= '0;
      fill        <= '0;
      last_output <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (int'(window_size) > MAX_WINDOW) begin
          window <= WIN_BITS'(MAX_WINDOW);
        end else begin
          window <= window_size;
        end
        total <= '0;
        idx   <= '0;
        fill  <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= (window == '0) ? ST_HOLD : ST_READ;
          end
        end
        ST_READ: begin
          total <= total_next;
          idx   <= idx_next;
          if (FILL_BITS'(idx) == fill) begin
            fill <= fill + FILL_BITS'(1);
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            last_output <= quo[SAMPLE_BITS-1:0];
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload and divider
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          sample <= sample_value;
          quo    <= TOTAL_BITS'(sample_value);
        end
      end
      ST_READ: begin
        quo <= total_next;
        rem <= '0;
        cnt <= CNT_BITS'(TOTAL_BITS - 1);
      end
      ST_DIV: begin
        quo <= {quo[TOTAL_BITS-2:0], rem_ge};
        rem <= rem_ge ? rem_dif[WIN_BITS-1:0] : rem_sh[WIN_BITS-1:0];
        cnt <= cnt - CNT_BITS'(1);
      end
      ST_HOLD: begin
        if (out_free) begin
          filtered_value <= quo[SAMPLE_BITS-1:0];
          previous_value <= last_output;
        end
      end
      default: begin
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_BITS'(fill) <= CMP_BITS'(window))
    else $error("fill count beyond window");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (window != '0) |-> (CMP_BITS'(idx) < CMP_BITS'(window)))
    else $error("write index outside window");

  a_no_read_bypass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (window != '0))
    else $error("store accessed while bypassed");

endmodule

`default_nettype wire

FILE: dv/running_sum_moving_average_unit_test.sv
module running_sum_moving_average_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_W = rsma_pkg::WIN_BITS;
  localparam int MAX_WIN = rsma_pkg::DEF_MAX_WINDOW;
  localparam int SAMPLE_W = rsma_pkg::DEF_SAMPLE_BITS;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE_CYCLES = 30;
  localparam int PRESSURE_AT = 500;
  localparam int PRESSURE_CYCLES = 600;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filt;
    logic [SAMPLE_W-1:0] prev;
  } avg_result_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [WIN_W-1:0]    win;
    logic [SAMPLE_W-1:0] sample;
    bit                  known;
    logic [SAMPLE_W-1:0] filt;
    logic [SAMPLE_W-1:0] prev;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [WIN_W-1:0]    window_size;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                out_valid;
  logic                out_ready;
  logic [SAMPLE_W-1:0] filtered_value;
  logic [SAMPLE_W-1:0] previous_value;

  // predictor state
  logic [WIN_W-1:0]    avg_window;
  logic [SAMPLE_W-1:0] avg_store [MAX_WIN];
  logic [15:0]         avg_total;
  logic [5:0]          avg_index;
  logic [SAMPLE_W-1:0] avg_last;

  avg_result_t pending_avgs[$];
  int          err_count;
  int          results_seen;
  int          sender_calm;

  dir_row_t dir_rows [26] = '{
    '{ROW_SAMPLE, 7'd0,   10'd0,    1'b1, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd1023, 10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd341,  1'b1, 10'd341,  10'd1023},
    '{ROW_SAMPLE, 7'd0,   10'd682,  1'b1, 10'd682,  10'd341},
    '{ROW_CFG,    7'd1,   10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd1023, 10'd682},
    '{ROW_SAMPLE, 7'd0,   10'd0,    1'b1, 10'd0,    10'd1023},
    '{ROW_CFG,    7'd2,   10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd511,  10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd1023, 10'd511},
    '{ROW_SAMPLE, 7'd0,   10'd0,    1'b1, 10'd511,  10'd1023},
    '{ROW_CFG,    7'd127, 10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd15,   10'd511},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd31,   10'd15},
    '{ROW_CFG,    7'd65,  10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd640,  1'b1, 10'd10,   10'd31},
    '{ROW_CFG,    7'd3,   10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd341,  10'd10},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd682,  10'd341},
    '{ROW_SAMPLE, 7'd0,   10'd1023, 1'b1, 10'd1023, 10'd682},
    '{ROW_SAMPLE, 7'd0,   10'd0,    1'b1, 10'd682,  10'd1023},
    '{ROW_SAMPLE, 7'd0,   10'd7,    1'b0, 10'd0,    10'd0},
    '{ROW_CFG,    7'd64,  10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd1,    1'b0, 10'd0,    10'd0},
    '{ROW_CFG,    7'd0,   10'd0,    1'b0, 10'd0,    10'd0},
    '{ROW_SAMPLE, 7'd0,   10'd5,    1'b1, 10'd5,    10'd0}
  };

  running_sum_moving_average_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .window_size    (window_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .previous_value (previous_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10ms;
    $display("** running_sum_moving_average_unit: FAILED **");
    $finish;
  end

  function automatic void clear_average();
    for (int i = 0; i < MAX_WIN; i++) avg_store[i] = '0;
    avg_total = '0;
    avg_index = '0;
  endfunction

  function automatic void set_window(input logic [WIN_W-1:0] w);
    avg_window = (w > MAX_WIN) ? WIN_W'(MAX_WIN) : w;
    clear_average();
  endfunction

  function automatic avg_result_t step_average(input logic [SAMPLE_W-1:0] s);
    avg_result_t res;
    int          t;
    int          q;
    logic [5:0]  idx;
    if (avg_window == 0) begin
      res.filt = s;
    end else begin
      idx = avg_index;
      avg_total = avg_total + 16'(s) - 16'(avg_store[idx]);
      avg_store[idx] = s;
      avg_index = (int'(idx) + 1 >= int'(avg_window)) ? 6'd0 : idx + 6'd1;
      t = int'(avg_total);
      q = t / int'(avg_window);
      res.filt = q[SAMPLE_W-1:0];
    end
    res.prev = avg_last;
    avg_last = res.filt;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      sender_calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return SAMPLE_W'($urandom_range(0, 15));
    return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
  endfunction

  function automatic logic [WIN_W-1:0] pick_window(input int phase);
    int r;
    case (phase)
      0: return '0;
      1: return WIN_W'(1);
      2: return WIN_W'(MAX_WIN);
      3: return '1;
      4: return WIN_W'(2);
      default: begin
        r = $urandom_range(0, 3);
        if (r == 0) return WIN_W'($urandom_range(0, (1 << WIN_W) - 1));
        if (r == 1) return WIN_W'($urandom_range(MAX_WIN - 4, MAX_WIN));
        return WIN_W'($urandom_range(1, 8));
      end
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit known,
                             input avg_result_t typed);
    int          gap;
    avg_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = step_average(s);
    pending_avgs.push_back(known ? typed : res);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    window_size <= w;
    @(posedge clk);
    set_window(w);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    avg_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_avgs.size() == 0) begin
        $display("%0t: result with no item pending, filtered %0d previous %0d",
                 $realtime, filtered_value, previous_value);
        err_count++;
      end else begin
        want = pending_avgs.pop_front();
        if (filtered_value !== want.filt) begin
          $display("%0t: filtered_value expected %0d actual %0d",
                   $realtime, want.filt, filtered_value);
          err_count++;
        end
        if (previous_value !== want.prev) begin
          $display("%0t: previous_value expected %0d actual %0d",
                   $realtime, want.prev, previous_value);
          err_count++;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin : receiver
    int  stall_left;
    int  quiet_left;
    int  r;
    bit  held;
    stall_left = 0;
    quiet_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= PRESSURE_AT) begin
        held = 1'b1;
        stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          quiet_left = $urandom_range(50, 200);
          out_ready <= 1'b1;
        end else if (r < 70) begin
          out_ready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    avg_result_t typed;
    logic [WIN_W-1:0] w;
    rst = 1'b1;
    cfg_we = 1'b0;
    window_size = '0;
    in_valid = 1'b0;
    sample_value = '0;
    err_count = 0;
    results_seen = 0;
    sender_calm = 0;
    avg_window = '0;
    avg_last = '0;
    clear_average();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_window(dir_rows[i].win);
      end else begin
        typed.filt = dir_rows[i].filt;
        typed.prev = dir_rows[i].prev;
        send_sample(dir_rows[i].sample, dir_rows[i].known, typed);
      end
    end

    typed = '0;
    for (int p = 0; p < PHASES; p++) begin
      w = pick_window(p);
      write_window(w);
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(), 1'b0, typed);
    end

    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** running_sum_moving_average_unit: PASSED **");
    end else begin
      $display("** running_sum_moving_average_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rsma_pkg.sv
sv/running_sum_moving_average_unit.sv
dv/running_sum_moving_average_unit_test.sv
